/* hw/rtl/twcws_pkg.sv */
`timescale 1ns / 1ps

package twcws_pkg;

    localparam int WORD_BITS = 16;
    localparam int CMD_BITS  = 16;
    localparam int HALF_BITS = 6;
    localparam int HOLD_BITS = 8;

    localparam logic [HALF_BITS-1:0] LAST_HALF = HALF_BITS'(2 * WORD_BITS - 1);

    localparam logic [HOLD_BITS-1:0] START_TICKS_RESET = 8'd20;
    localparam logic [HOLD_BITS-1:0] STOP_TICKS_RESET  = 8'd4;

    // register indexes on the configuration port
    localparam logic CFG_START_TICKS = 1'b0;
    localparam logic CFG_STOP_TICKS  = 1'b1;

    // operation codes
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_SEND = 1'b1;

    typedef enum logic [4:0] {
        PH_IDLE     = 5'b00001,
        PH_LOADED   = 5'b00010,
        PH_LEAD     = 5'b00100,
        PH_CLOCKING = 5'b01000,
        PH_TAIL     = 5'b10000
    } phase_t;

    typedef struct packed {
        logic                operation;
        logic [CMD_BITS-1:0] command_word;
    } in_item_t;

    typedef struct packed {
        logic clock_line;
        logic data_line;
        logic busy_res;
        logic send_rejected;
    } out_item_t;

endpackage

/* hw/rtl/twcws_core.sv */
`timescale 1ns / 1ps

module twcws_core import twcws_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 step,
    input  in_item_t             item,
    input  logic [HOLD_BITS-1:0] start_ticks,
    input  logic [HOLD_BITS-1:0] stop_ticks,
    output out_item_t            result
);

    phase_t                 phase_reg, phase_next;
    logic [WORD_BITS-1:0]   shift_reg, shift_next;
    logic [HOLD_BITS-1:0]   hold_reg, hold_next;
    logic [HALF_BITS-1:0]   half_reg, half_next;
    logic                   clk_reg, clk_next;
    logic                   data_reg, data_next;
    logic                   rejected;
    logic [HOLD_BITS-1:0]   hold_inc;
    logic [HALF_BITS-1:0]   half_inc;

    assign hold_inc = hold_reg + 1'b1;
    assign half_inc = half_reg + 1'b1;

    always_comb begin
        phase_next = phase_reg;
        shift_next = shift_reg;
        hold_next  = hold_reg;
        half_next  = half_reg;
        clk_next   = clk_reg;
        data_next  = data_reg;
        rejected   = 1'b0;

        if (item.operation == OP_SEND) begin
            if (phase_reg == PH_IDLE || phase_reg == PH_LOADED || phase_reg == PH_LEAD
                || phase_reg == PH_CLOCKING || phase_reg == PH_TAIL) begin
                if (phase_reg == PH_IDLE) begin
                    shift_next = WORD_BITS'(item.command_word);
                    phase_next = PH_LOADED;
                end else begin
                    rejected = 1'b1;
                end
            end else begin
                // stray phase code acts as idle
                shift_next = WORD_BITS'(item.command_word);
                phase_next = PH_LOADED;
            end
        end else begin
            case (phase_reg)
                PH_LOADED: begin
                    data_next  = shift_reg[WORD_BITS-1];
                    shift_next = shift_reg << 1;
                    clk_next   = 1'b0;
                    hold_next  = '0;
                    phase_next = PH_LEAD;
                end
                PH_LEAD: begin
                    hold_next = hold_inc;
                    if (hold_inc == start_ticks) begin
                        hold_next  = '0;
                        clk_next   = 1'b1;
                        half_next  = '0;
                        phase_next = PH_CLOCKING;
                    end
                end
                PH_CLOCKING: begin
                    half_next = half_inc;
                    if (half_inc < LAST_HALF) begin
                        if (half_inc[0]) begin
                            clk_next   = 1'b0;
                            data_next  = shift_reg[WORD_BITS-1];
                            shift_next = shift_reg << 1;
                        end else begin
                            clk_next = 1'b1;
                        end
                    end else begin
                        clk_next   = 1'b0;
                        half_next  = '0;
                        hold_next  = '0;
                        phase_next = PH_TAIL;
                    end
                end
                PH_TAIL: begin
                    hold_next = hold_inc;
                    if (hold_inc == stop_ticks) begin
                        hold_next  = '0;
                        half_next  = '0;
                        clk_next   = 1'b1;
                        phase_next = PH_IDLE;
                    end
                end
                PH_IDLE: begin
                end
                default: begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    assign result.clock_line    = clk_next;
    assign result.data_line     = data_next;
    assign result.busy_res      = (phase_next != PH_IDLE);
    assign result.send_rejected = rejected;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            shift_reg <= '0;
            hold_reg  <= '0;
            half_reg  <= '0;
            clk_reg   <= 1'b1;
            data_reg  <= 1'b1;
        end else if (step) begin
            phase_reg <= phase_next;
            shift_reg <= shift_next;
            hold_reg  <= hold_next;
            half_reg  <= half_next;
            clk_reg   <= clk_next;
            data_reg  <= data_next;
        end
    end

endmodule

/* hw/rtl/two_wire_command_word_sender.sv */
`timescale 1ns / 1ps

// Sends a 16-bit command word MSB first on a clock and data line, one step per
// input item: a tick item advances the line state by one half-period or one hold
// tick, a send item loads the word when idle and is flagged as rejected while a
// word is in flight. Each item gives exactly one result with the line levels
// after it. Every item goes through a single next-state stage into the result
// register, so an item is accepted every cycle while the result register is
// free or drained. start_ticks (index 0) and stop_ticks (index 1) set how long
// clock is held low before and after the data bits; a value of 0 means 256 ticks.
module two_wire_command_word_sender import twcws_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  in_item_t             s_payload,
    output logic                 m_valid,
    input  logic                 m_ready,
    output out_item_t            m_payload,
    input  logic                 cfg_wr_en,
    input  logic                 cfg_index,
    input  logic [HOLD_BITS-1:0] cfg_data
);

    logic                 m_valid_reg;
    out_item_t            m_payload_reg;
    logic [HOLD_BITS-1:0] start_ticks_reg;
    logic [HOLD_BITS-1:0] stop_ticks_reg;
    logic                 step;
    out_item_t            result;

    assign s_ready   = !m_valid_reg || m_ready;
    assign step      = s_valid && s_ready;
    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    twcws_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step        (step),
        .item        (s_payload),
        .start_ticks (start_ticks_reg),
        .stop_ticks  (stop_ticks_reg),
        .result      (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_ticks_reg <= START_TICKS_RESET;
            stop_ticks_reg  <= STOP_TICKS_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_START_TICKS: start_ticks_reg <= cfg_data;
                CFG_STOP_TICKS:  stop_ticks_reg  <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // result register, refilled in the same cycle it drains
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (step) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            m_payload_reg <= result;
        end
    end

endmodule
